// File: design/bfa_pkg.sv
// Shared types and constants for the bitmap frame allocator.
// Used by bfa_csr, bfa_map, bfa_scan and bitmap_frame_allocator; no dependencies.
`default_nettype none

package bfa_pkg;

   localparam int NUM_FRAMES_DEFAULT = 4096;
   localparam int FRAME_SHIFT        = 12;   // log2 of the 4 KiB frame size
   localparam int ADDR_W             = 24;
   localparam int FIDX_W             = ADDR_W - FRAME_SHIFT;
   localparam int HINT_W             = 13;
   localparam int FC_W               = 13;
   localparam int WORD_BITS          = 16;
   localparam int BIT_W              = 4;
   localparam int WIDX_W             = HINT_W - BIT_W;
   localparam int CSR_DATA_W         = 32;
   localparam int CSR_ADDR_W         = 2;

   localparam logic [HINT_W-1:0] HINT_RESET = HINT_W'(2);
   localparam logic [FC_W-1:0]   FC_RESET   = FC_W'(4096);

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_NONE    = 2'd1,
      STATUS_BADADDR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      SEQ_CLEAR,
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_FREE,
      SEQ_REPLY
   } seq_state_type;

   typedef struct packed {
      op_type              operation;
      logic [ADDR_W-1:0]   frame_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   allocated_address;
      status_type          status;
   } rsp_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] bit_idx;
      logic             last;
   } scan_result_type;

endpackage

`default_nettype wire

// File: design/bitmap_frame_allocator.sv
// Bitmap page frame allocator with a next-fit search pointer.
// Items arrive on the req_ channel (operation, frame_address) and each gives
// exactly one item on the rsp_ channel (allocated_address, status). The
// frame_count register is written through the APB-style port at any address.
// An allocate scans the free map from the hint, one 16-bit map word per cycle
// through a single scanner, until a free frame or the last word is found; an
// allocate with the hint at or past the end goes straight to the reply. A
// free reads, then modify-writes, then replies; a rejected free goes straight
// to the reply. The map memory's single read port sets the scan rate.
// The result then sits in an output register until rsp_ready takes it; a new
// item is accepted meanwhile, and its reply waits if the register is still
// full. After reset the block sweeps every map word (NUM_FRAMES/16 rounded
// up, 256 by default) to all free, one word per cycle, and holds req_ready
// low during the sweep; configuration writes are taken at any time. Reset
// sets the hint to 2 and frame_count to 4096.
// Depends on bfa_pkg, bfa_csr, bfa_map and bfa_scan.
`default_nettype none

module bitmap_frame_allocator #(
   parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire bfa_pkg::req_type               req_payload,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output bfa_pkg::rsp_type                    rsp_payload,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [bfa_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [bfa_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [bfa_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);

   localparam int BitW   = bfa_pkg::BIT_W;
   localparam int WidxW  = bfa_pkg::WIDX_W;
   localparam int HintW  = bfa_pkg::HINT_W;
   localparam int FidxW  = bfa_pkg::FIDX_W;
   localparam int WordW  = bfa_pkg::WORD_BITS;
   localparam int ShiftW = bfa_pkg::FRAME_SHIFT;

   bfa_pkg::seq_state_type   state_ff, state_in;
   logic [HintW-1:0]         hint_ff, hint_in;
   logic [WidxW-1:0]         word_ff, word_in;
   logic [FidxW-1:0]         fidx_ff, fidx_in;
   bfa_pkg::rsp_type         res_ff, res_in;
   bfa_pkg::rsp_type         rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [HintW-1:0]         n_eff;
   logic                     map_rd_en, map_wr_en, map_busy;
   logic [WidxW-1:0]         map_rd_word, map_wr_word;
   logic [WordW-1:0]         map_rd_data, map_wr_data;
   bfa_pkg::scan_result_type scan;
   logic [HintW-1:0]         found_frame;
   logic [FidxW-1:0]         req_fidx;

   bfa_csr #(
      .NUM_FRAMES(NUM_FRAMES)
   ) u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .n_eff  (n_eff)
   );

   bfa_map #(
      .NUM_FRAMES(NUM_FRAMES)
   ) u_map (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (map_rd_en),
      .rd_word(map_rd_word),
      .rd_data(map_rd_data),
      .wr_en  (map_wr_en),
      .wr_word(map_wr_word),
      .wr_data(map_wr_data),
      .busy   (map_busy)
   );

   bfa_scan u_scan (
      .word    (map_rd_data),
      .word_idx(word_ff),
      .hint    (hint_ff),
      .n_eff   (n_eff),
      .result  (scan)
   );

   assign found_frame = {word_ff, scan.bit_idx};
   assign req_fidx    = req_payload.frame_address[bfa_pkg::ADDR_W-1:ShiftW];

   always_comb begin
      state_in     = state_ff;
      hint_in      = hint_ff;
      word_in      = word_ff;
      fidx_in      = fidx_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      map_rd_en    = 1'b0;
      map_rd_word  = word_ff;
      map_wr_en    = 1'b0;
      map_wr_word  = word_ff;
      map_wr_data  = map_rd_data;
      req_ready    = (state_ff == bfa_pkg::SEQ_IDLE);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         bfa_pkg::SEQ_CLEAR: begin
            if (!map_busy) begin
               state_in = bfa_pkg::SEQ_IDLE;
            end
         end
         bfa_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               res_in.allocated_address = '0;
               if (req_payload.operation == bfa_pkg::OP_ALLOC) begin
                  if (hint_ff < n_eff) begin
                     map_rd_en   = 1'b1;
                     map_rd_word = hint_ff[HintW-1:BitW];
                     word_in     = hint_ff[HintW-1:BitW];
                     state_in    = bfa_pkg::SEQ_SCAN;
                  end else begin
                     res_in.status = bfa_pkg::STATUS_NONE;
                     state_in      = bfa_pkg::SEQ_REPLY;
                  end
               end else if ((req_payload.frame_address[ShiftW-1:0] == '0) &&
                            (HintW'(req_fidx) < n_eff)) begin
                  map_rd_en   = 1'b1;
                  map_rd_word = WidxW'(req_fidx[FidxW-1:BitW]);
                  fidx_in     = req_fidx;
                  state_in    = bfa_pkg::SEQ_FREE;
               end else begin
                  res_in.status = bfa_pkg::STATUS_BADADDR;
                  state_in      = bfa_pkg::SEQ_REPLY;
               end
            end
         end
         bfa_pkg::SEQ_SCAN: begin
            if (scan.found) begin
               map_wr_en   = 1'b1;
               map_wr_data = map_rd_data & ~(WordW'(1) << scan.bit_idx);
               hint_in     = found_frame + HintW'(1);
               res_in.allocated_address = {found_frame[FidxW-1:0], ShiftW'(0)};
               res_in.status = bfa_pkg::STATUS_DONE;
               state_in      = bfa_pkg::SEQ_REPLY;
            end else if (scan.last) begin
               // Nothing free up to the end: park the hint on the last frame.
               hint_in       = n_eff - HintW'(1);
               res_in.status = bfa_pkg::STATUS_NONE;
               state_in      = bfa_pkg::SEQ_REPLY;
            end else begin
               word_in     = word_ff + WidxW'(1);
               map_rd_en   = 1'b1;
               map_rd_word = word_ff + WidxW'(1);
            end
         end
         bfa_pkg::SEQ_FREE: begin
            map_wr_en     = 1'b1;
            map_wr_word   = WidxW'(fidx_ff[FidxW-1:BitW]);
            map_wr_data   = map_rd_data | (WordW'(1) << fidx_ff[BitW-1:0]);
            hint_in       = HintW'(fidx_ff);
            res_in.status = bfa_pkg::STATUS_DONE;
            state_in      = bfa_pkg::SEQ_REPLY;
         end
         bfa_pkg::SEQ_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = bfa_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = bfa_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfa_pkg::SEQ_CLEAR;
         hint_ff      <= bfa_pkg::HINT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      fidx_ff <= fidx_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_fail_has_no_address: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status != bfa_pkg::STATUS_DONE))
         |-> (rsp_payload.allocated_address == '0))
      else $error("failed item carries a nonzero address");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      map_busy |-> !req_ready)
      else $error("item accepted during the map clearing sweep");

   a_scan_hint_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfa_pkg::SEQ_SCAN) |-> (hint_ff < n_eff))
      else $error("scan running with the hint past the managed count");

   a_free_moves_hint: assert property (@(posedge clock) disable iff (reset)
      $past((state_ff == bfa_pkg::SEQ_FREE) && !reset)
         |-> (hint_ff == HintW'($past(fidx_ff))))
      else $error("free did not move the hint to the freed frame");

endmodule

`default_nettype wire

// File: design/bfa_csr.sv
// Configuration register block: holds frame_count and derives the effective
// number of managed frames. Depends on bfa_pkg.
`default_nettype none

module bfa_csr #(
   parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [bfa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [bfa_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [bfa_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready,
   output logic      [bfa_pkg::HINT_W-1:0]       n_eff
);

   logic [bfa_pkg::FC_W-1:0] fc_ff, fc_in;
   logic                     wr_go;

   // Only one word of register space exists, so every byte lane address hits it.
   assign wr_go = psel && penable && pwrite && (paddr == paddr);

   always_comb begin
      fc_in = fc_ff;
      if (wr_go) begin
         fc_in = pwdata[bfa_pkg::FC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= bfa_pkg::FC_RESET;
      end else begin
         fc_ff <= fc_in;
      end
   end

   // A count larger than the map is clamped to the map size.
   always_comb begin
      if (17'(fc_ff) > 17'(NUM_FRAMES)) begin
         n_eff = bfa_pkg::HINT_W'(NUM_FRAMES);
      end else begin
         n_eff = fc_ff;
      end
   end

   assign prdata = bfa_pkg::CSR_DATA_W'(fc_ff);
   assign pready = 1'b1;

endmodule

`default_nettype wire

// File: design/bfa_map.sv
// Free map storage: one bit per frame, packed into 16-bit words, with a
// clearing sweep after reset that marks every frame free. Depends on bfa_pkg.
`default_nettype none

module bfa_map #(
   parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [bfa_pkg::WIDX_W-1:0]    rd_word,
   output logic      [bfa_pkg::WORD_BITS-1:0] rd_data,
   input  wire logic                          wr_en,
   input  wire logic [bfa_pkg::WIDX_W-1:0]    wr_word,
   input  wire logic [bfa_pkg::WORD_BITS-1:0] wr_data,
   output logic                               busy
);

   // A partly used last word still needs storage for its frames.
   localparam int Words  = (NUM_FRAMES + bfa_pkg::WORD_BITS - 1) / bfa_pkg::WORD_BITS;
   localparam int WaddrW = (Words > 1) ? $clog2(Words) : 1;

   logic [bfa_pkg::WORD_BITS-1:0] mem [Words];
   logic [bfa_pkg::WORD_BITS-1:0] rd_data_ff;
   logic [WaddrW-1:0]             clr_ff, clr_in;
   logic                          busy_ff, busy_in;
   logic [15:0]                   ra_wide, wa_wide;
   logic [WaddrW-1:0]             ra, wa_sel;
   logic [bfa_pkg::WORD_BITS-1:0] wd_sel;
   logic                          we_sel;

   assign ra_wide = 16'(rd_word);
   assign wa_wide = 16'(wr_word);
   assign ra      = ra_wide[WaddrW-1:0];

   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + WaddrW'(1);
         if (clr_ff == WaddrW'(Words - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // The sweep owns the write port until every word holds all ones.
   always_comb begin
      if (busy_ff) begin
         we_sel = 1'b1;
         wa_sel = clr_ff;
         wd_sel = '1;
      end else begin
         we_sel = wr_en;
         wa_sel = wa_wide[WaddrW-1:0];
         wd_sel = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we_sel) begin
         mem[wa_sel] <= wd_sel;
      end
      if (rd_en) begin
         rd_data_ff <= mem[ra];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule

`default_nettype wire

// File: design/bfa_scan.sv
// Word scanner: masks one map word to the frames between the hint and
// the managed count and finds the lowest free one. Depends on bfa_pkg.
`default_nettype none

module bfa_scan (
   input  wire logic [bfa_pkg::WORD_BITS-1:0] word,
   input  wire logic [bfa_pkg::WIDX_W-1:0]    word_idx,
   input  wire logic [bfa_pkg::HINT_W-1:0]    hint,
   input  wire logic [bfa_pkg::HINT_W-1:0]    n_eff,
   output bfa_pkg::scan_result_type           result
);

   localparam int BitW = bfa_pkg::BIT_W;

   logic [bfa_pkg::WORD_BITS-1:0] avail;
   logic [bfa_pkg::HINT_W:0]      next_base;

   always_comb begin
      logic [bfa_pkg::HINT_W-1:0] frame;
      for (int b = 0; b < bfa_pkg::WORD_BITS; b++) begin
         frame    = {word_idx, BitW'(b)};
         avail[b] = word[b] && (frame >= hint) && (frame < n_eff);
      end
   end

   always_comb begin
      result.bit_idx = '0;
      for (int b = bfa_pkg::WORD_BITS - 1; b >= 0; b--) begin
         if (avail[b]) begin
            result.bit_idx = BitW'(b);
         end
      end
      result.found = |avail;
      // The word is the last one when the next word starts at or past the count.
      next_base   = {({1'b0, word_idx} + (bfa_pkg::WIDX_W + 1)'(1)), BitW'(0)};
      result.last = next_base >= {1'b0, n_eff};
   end

endmodule

`default_nettype wire
